>>> rtl/core/jhd_pkg.sv
// ----------------------------------------------------------------------------
// jhd_pkg
// Shared types, codes and constants of the JPEG Huffman block decoder.
// ----------------------------------------------------------------------------
package jhd_pkg;

  // default table sizes
  localparam int AcSymbolsDef  = 162;
  localparam int DcSymbolsDef  = 12;
  localparam int MaxCodeLenDef = 16;

  // special AC symbols and limits
  localparam logic [7:0] SymZrl    = 8'hF0;
  localparam logic [7:0] SymEob    = 8'h00;
  localparam int         NumCoefs  = 64;
  localparam int         DcSizeMax = 11;
  localparam int         AcSizeMax = 10;
  localparam int         ZrlRun    = 16;

  typedef enum logic [1:0] {
    CMD_BIT         = 2'd0,
    CMD_LOAD_COUNT  = 2'd1,
    CMD_LOAD_SYMBOL = 2'd2,
    CMD_START       = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_CODE  = 3'd1,
    ST_DC_SIZE  = 3'd2,
    ST_AC_SIZE  = 3'd3,
    ST_RUN_OVER = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_DC_SYM = 3'd0,
    PH_DC_MAG = 3'd1,
    PH_AC_SYM = 3'd2,
    PH_AC_MAG = 3'd3,
    PH_ERROR  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_SYMBOL,
    S_MAG,
    S_ZEROS
  } state_e;

  localparam logic [5:0] ZIGZAG [NumCoefs] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // natural position of a zigzag position
  function automatic logic [5:0] zigzag(input logic [5:0] p);
    return ZIGZAG[p];
  endfunction

endpackage

>>> rtl/core/jpeg_huffman_block_decoder_core.sv
// ----------------------------------------------------------------------------
// jpeg_huffman_block_decoder_core
// Baseline JPEG entropy decoder, one scan bit per input beat.
// ----------------------------------------------------------------------------
// Each input beat carries one command. Table loads and scan starts are taken
// in the idle state. A Huffman code bit is accepted, then checked against the
// count read from the count memory; the bit that completes a code adds a
// symbol memory read, and the last magnitude bit passes the magnitude state.
// Results leave one per cycle through an output register while the receiver
// is ready; zero runs and end-of-block bursts emit one zero coefficient per
// cycle, only while it is ready, and hold off input until the burst is out.
// Tables are read only on bit beats or outside idle, so no read and write
// overlap on either memory. Table contents are undefined until loaded.
module jpeg_huffman_block_decoder_core import jhd_pkg::*; #(
  parameter int AC_SYMBOLS      = AcSymbolsDef,
  parameter int DC_SYMBOLS      = DcSymbolsDef,
  parameter int MAX_CODE_LENGTH = MaxCodeLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic               entropy_bit_i,
  input  logic               table_id_i,
  input  logic               table_is_ac_i,
  input  logic [7:0]         load_position_i,
  input  logic [7:0]         load_value_i,
  input  logic [1:0]         predictor_select_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         coef_index_o,
  output logic signed [15:0] coef_value_o,
  output logic               block_last_o,
  output logic [2:0]         status_o
);

  localparam int CntDepth = 4 * MAX_CODE_LENGTH;
  localparam int Spp      = DC_SYMBOLS + AC_SYMBOLS;
  localparam int SymDepth = 2 * Spp;
  localparam int Caw      = $clog2(CntDepth);
  localparam int Saw      = $clog2(SymDepth);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [15:0] code_accum_q, code_accum_d;
  logic [16:0] first_code_q, first_code_d;
  logic [7:0]  first_index_q, first_index_d;
  logic [4:0]  code_length_q, code_length_d;
  logic [10:0] mag_q, mag_d;
  logic [3:0]  bits_left_q, bits_left_d;
  logic [6:0]  pos_q, pos_d;
  logic [6:0]  run_cnt_q, run_cnt_d;
  logic [1:0]  pred_sel_q, pred_sel_d;
  logic        tbl_q, tbl_d;
  logic        bit_rdy;
  logic signed [15:0] pred_q [3];
  logic signed [15:0] pred_d [3];

  logic              out_valid_q, out_valid_d;
  logic [5:0]        out_index_q, out_index_d;
  logic signed [15:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  status_e           out_status_q, out_status_d;

  logic       accept, can_emit;
  cmd_e       cmd;
  logic       cnt_we, sym_we, cnt_re, sym_re;
  logic [Caw-1:0] cnt_waddr, cnt_raddr;
  logic [Saw-1:0] sym_waddr, sym_raddr;
  logic [7:0] cnt_rdata, sym_rdata;

  // symbol search and symbol decode
  logic        ph_ac, ph_sym;
  logic [16:0] diff;
  logic [8:0]  idx;
  logic        match, no_code;
  logic [8:0]  fi_sum;
  logic [18:0] fc_sum;
  logic        dc_bad, ac_zrl, ac_eob, run_over, ac_bad, sym_err;
  logic [4:0]  run;
  logic [3:0]  size;
  logic [6:0]  burst;
  logic [3:0]  ext_s;
  logic signed [11:0] ext_v;
  logic signed [16:0] dc_sum;
  logic signed [15:0] dc_sat;

  assign cmd        = cmd_e'(command_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;
  assign ph_ac      = (phase_q == PH_AC_SYM);
  assign ph_sym     = (phase_q == PH_DC_SYM) || ph_ac;

  // table write and read addressing
  assign cnt_we    = accept && (cmd == CMD_LOAD_COUNT) &&
                     (int'(load_position_i) < MAX_CODE_LENGTH);
  assign cnt_waddr = Caw'((2 * int'(table_id_i) + int'(table_is_ac_i)) * MAX_CODE_LENGTH
                          + int'(load_position_i));
  assign sym_we    = accept && (cmd == CMD_LOAD_SYMBOL) &&
                     (int'(load_position_i) < (table_is_ac_i ? AC_SYMBOLS : DC_SYMBOLS));
  assign sym_waddr = Saw'(int'(table_id_i) * Spp + (table_is_ac_i ? DC_SYMBOLS : 0)
                          + int'(load_position_i));
  assign cnt_re    = accept && (cmd == CMD_BIT) && ph_sym;
  assign cnt_raddr = Caw'((2 * int'(table_id_i) + int'(ph_ac)) * MAX_CODE_LENGTH
                          + int'(code_length_q));

  // canonical code check against the count just read
  always_comb begin
    diff    = {1'b0, code_accum_q} - first_code_q;
    idx     = {1'b0, first_index_q} + diff[8:0];
    match   = ({1'b0, code_accum_q} >= first_code_q) && (diff < {9'd0, cnt_rdata}) &&
              (int'(idx) < (ph_ac ? AC_SYMBOLS : DC_SYMBOLS));
    no_code = !match && (int'(code_length_q) >= MAX_CODE_LENGTH);
    fi_sum  = {1'b0, first_index_q} + {1'b0, cnt_rdata};
    fc_sum  = {1'b0, first_code_q + {9'd0, cnt_rdata}, 1'b0};
  end

  assign sym_re    = (state_q == S_COUNT) && match;
  assign sym_raddr = Saw'(int'(tbl_q) * Spp + (ph_ac ? DC_SYMBOLS : 0) + int'(idx));

  // symbol classification
  always_comb begin
    ac_zrl   = (sym_rdata == SymZrl);
    ac_eob   = (sym_rdata == SymEob);
    run      = ac_zrl ? 5'(ZrlRun) : {1'b0, sym_rdata[7:4]};
    size     = sym_rdata[3:0];
    dc_bad   = int'(sym_rdata) > DcSizeMax;
    run_over = (int'(pos_q) + int'(run)) >= NumCoefs;
    ac_bad   = !ac_zrl && (int'(size) > AcSizeMax);
    sym_err  = ph_ac ? (!ac_eob && (run_over || ac_bad)) : dc_bad;
    if (ac_eob) begin
      burst = 7'(NumCoefs - int'(pos_q));
    end else begin
      burst = {2'b0, run} + 7'((size == 4'd0) && !ac_zrl);
    end
  end

  // magnitude sign extension and predictor sum
  always_comb begin
    ext_s = (int'(code_length_q) > DcSizeMax) ? 4'(DcSizeMax) : code_length_q[3:0];
    if (ext_s == 4'd0) begin
      ext_v = '0;
    end else if (mag_q[ext_s - 4'd1]) begin
      ext_v = signed'({1'b0, mag_q});
    end else begin
      ext_v = signed'({1'b0, mag_q}) - signed'((12'd1 << ext_s) - 12'd1);
    end
    dc_sum = 17'(pred_q[pred_sel_q]) +
             ((state_q == S_MAG) ? 17'(ext_v) : 17'sd0);
    if (dc_sum > 17'sd32767) begin
      dc_sat = 16'sh7fff;
    end else if (dc_sum < -17'sd32768) begin
      dc_sat = -16'sh8000;
    end else begin
      dc_sat = dc_sum[15:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd == CMD_BIT) begin
          if (ph_sym) begin
            state_d = S_COUNT;
          end else if (bit_rdy) begin
            state_d = S_MAG;
          end
        end
      end
      S_COUNT: begin
        if (match) begin
          state_d = S_SYMBOL;
        end else if (!no_code || can_emit) begin
          state_d = S_IDLE;
        end
      end
      S_SYMBOL: begin
        if (can_emit || (ph_ac && !sym_err)) begin
          state_d = (ph_ac && !sym_err && burst != 7'd0) ? S_ZEROS : S_IDLE;
        end
      end
      S_MAG: begin
        if (can_emit) begin
          state_d = S_IDLE;
        end
      end
      S_ZEROS: begin
        if (can_emit && run_cnt_q == 7'd1) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign bit_rdy = (phase_q == PH_DC_MAG || phase_q == PH_AC_MAG) && (bits_left_q <= 4'd1);

  // datapath and result register
  always_comb begin
    logic emit;
    logic [5:0] p;
    emit          = 1'b0;
    p             = pos_q[5:0];
    phase_d       = phase_q;
    code_accum_d  = code_accum_q;
    first_code_d  = first_code_q;
    first_index_d = first_index_q;
    code_length_d = code_length_q;
    mag_d         = mag_q;
    bits_left_d   = bits_left_q;
    pos_d         = pos_q;
    run_cnt_d     = run_cnt_q;
    pred_sel_d    = pred_sel_q;
    tbl_d         = tbl_q;
    pred_d        = pred_q;
    out_index_d   = out_index_q;
    out_value_d   = out_value_q;
    out_last_d    = out_last_q;
    out_status_d  = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd == CMD_START) begin
          pred_d        = '{default: '0};
          code_accum_d  = '0;
          first_code_d  = '0;
          first_index_d = '0;
          code_length_d = '0;
          phase_d       = PH_DC_SYM;
          mag_d         = '0;
          bits_left_d   = '0;
          pos_d         = '0;
          pred_sel_d    = '0;
        end else if (accept && cmd == CMD_BIT) begin
          tbl_d = table_id_i;
          if (ph_sym) begin
            if (!ph_ac && code_length_q == 5'd0) begin
              pred_sel_d = (predictor_select_i > 2'd2) ? 2'd2 : predictor_select_i;
            end
            code_accum_d  = {code_accum_q[14:0], entropy_bit_i};
            code_length_d = code_length_q + 5'd1;
          end else if (phase_q != PH_ERROR) begin
            mag_d       = {mag_q[9:0], entropy_bit_i};
            bits_left_d = (bits_left_q != 4'd0) ? bits_left_q - 4'd1 : 4'd0;
          end
        end
      end
      S_COUNT: begin
        if (match) begin
          code_accum_d  = '0;
          first_code_d  = '0;
          first_index_d = '0;
          code_length_d = '0;
        end else if (no_code) begin
          if (can_emit) begin
            emit          = 1'b1;
            out_index_d   = '0;
            out_value_d   = '0;
            out_last_d    = 1'b1;
            out_status_d  = ST_NO_CODE;
            phase_d       = PH_ERROR;
            code_accum_d  = '0;
            first_code_d  = '0;
            first_index_d = '0;
            code_length_d = '0;
          end
        end else begin
          first_index_d = fi_sum[8] ? 8'hff : fi_sum[7:0];
          first_code_d  = (fc_sum > 19'h1ffff) ? 17'h1ffff : fc_sum[16:0];
        end
      end
      S_SYMBOL: begin
        if (sym_err) begin
          if (can_emit) begin
            emit         = 1'b1;
            out_index_d  = '0;
            out_value_d  = '0;
            out_last_d   = 1'b1;
            out_status_d = !ph_ac ? ST_DC_SIZE : (run_over ? ST_RUN_OVER : ST_AC_SIZE);
            phase_d      = PH_ERROR;
          end
        end else if (!ph_ac) begin
          if (sym_rdata == 8'd0) begin
            // zero-size DC: predictor value as it stands
            if (can_emit) begin
              emit         = 1'b1;
              pred_d[pred_sel_q] = dc_sat;
              out_index_d  = zigzag(6'd0);
              out_value_d  = dc_sat;
              out_last_d   = 1'b0;
              out_status_d = ST_OK;
              pos_d        = 7'd1;
              phase_d      = PH_AC_SYM;
            end
          end else if (can_emit) begin
            phase_d       = PH_DC_MAG;
            code_length_d = sym_rdata[4:0];
            bits_left_d   = sym_rdata[3:0];
            mag_d         = '0;
          end
        end else begin
          run_cnt_d = burst;
          if (!ac_eob && !ac_zrl && size != 4'd0) begin
            phase_d       = PH_AC_MAG;
            code_length_d = {1'b0, size};
            bits_left_d   = size;
            mag_d         = '0;
          end
        end
      end
      S_MAG: begin
        if (can_emit) begin
          emit          = 1'b1;
          code_length_d = '0;
          mag_d         = '0;
          out_status_d  = ST_OK;
          if (phase_q == PH_DC_MAG) begin
            pred_d[pred_sel_q] = dc_sat;
            out_index_d = zigzag(6'd0);
            out_value_d = dc_sat;
            out_last_d  = 1'b0;
            pos_d       = 7'd1;
            phase_d     = PH_AC_SYM;
          end else begin
            out_index_d = zigzag(p);
            out_value_d = 16'(ext_v);
            out_last_d  = (p == 6'd63);
            pos_d       = (p == 6'd63) ? 7'd0 : pos_q + 7'd1;
            phase_d     = (p == 6'd63) ? PH_DC_SYM : PH_AC_SYM;
          end
        end
      end
      S_ZEROS: begin
        // one zero coefficient per beat while the receiver is ready; wrap ends the block
        if (can_emit) begin
          emit         = 1'b1;
          out_index_d  = zigzag(p);
          out_value_d  = '0;
          out_last_d   = (p == 6'd63);
          out_status_d = ST_OK;
          run_cnt_d    = run_cnt_q - 7'd1;
          if (p == 6'd63) begin
            pos_d   = '0;
            phase_d = PH_DC_SYM;
          end else begin
            pos_d = pos_q + 7'd1;
          end
        end
      end
      default: ;
    endcase

    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= PH_DC_SYM;
      code_accum_q  <= '0;
      first_code_q  <= '0;
      first_index_q <= '0;
      code_length_q <= '0;
      mag_q         <= '0;
      bits_left_q   <= '0;
      pos_q         <= '0;
      run_cnt_q     <= '0;
      pred_sel_q    <= '0;
      pred_q        <= '{default: '0};
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      code_accum_q  <= code_accum_d;
      first_code_q  <= first_code_d;
      first_index_q <= first_index_d;
      code_length_q <= code_length_d;
      mag_q         <= mag_d;
      bits_left_q   <= bits_left_d;
      pos_q         <= pos_d;
      run_cnt_q     <= run_cnt_d;
      pred_sel_q    <= pred_sel_d;
      pred_q        <= pred_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tbl_q        <= tbl_d;
    out_index_q  <= out_index_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  jhd_tables #(
    .CNT_DEPTH(CntDepth),
    .SYM_DEPTH(SymDepth)
  ) u_tables (
    .clk_i       (clk_i),
    .wdata_i     (load_value_i),
    .cnt_we_i    (cnt_we),
    .cnt_waddr_i (cnt_waddr),
    .cnt_re_i    (cnt_re),
    .cnt_raddr_i (cnt_raddr),
    .cnt_rdata_o (cnt_rdata),
    .sym_we_i    (sym_we),
    .sym_waddr_i (sym_waddr),
    .sym_re_i    (sym_re),
    .sym_raddr_i (sym_raddr),
    .sym_rdata_o (sym_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign coef_index_o = out_index_q;
  assign coef_value_o = out_value_q;
  assign block_last_o = out_last_q;
  assign status_o     = out_status_q;

  // error beats carry no coefficient and close the block
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> block_last_o && coef_value_o == 16'sd0 &&
    coef_index_o == 6'd0)
    else $error("error beat with coefficient payload");

  // block position stays inside the block
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < 7'(NumCoefs))
    else $error("coefficient position out of range");

  // a zero burst always has zeros left to send
  a_burst_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ZEROS |-> run_cnt_q != 7'd0)
    else $error("empty zero burst");

  // tables are never written while a read is in flight
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_we || sym_we) |-> state_q == S_IDLE && !sym_re)
    else $error("table write during table read");

endmodule

>>> rtl/core/jhd_tables.sv
// ----------------------------------------------------------------------------
// jhd_tables
// Huffman count memory and symbol memory, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module jhd_tables import jhd_pkg::*; #(
  parameter int CNT_DEPTH = 4 * MaxCodeLenDef,
  parameter int SYM_DEPTH = 2 * (DcSymbolsDef + AcSymbolsDef)
) (
  input  logic                         clk_i,
  input  logic [7:0]                   wdata_i,
  input  logic                         cnt_we_i,
  input  logic [$clog2(CNT_DEPTH)-1:0] cnt_waddr_i,
  input  logic                         cnt_re_i,
  input  logic [$clog2(CNT_DEPTH)-1:0] cnt_raddr_i,
  output logic [7:0]                   cnt_rdata_o,
  input  logic                         sym_we_i,
  input  logic [$clog2(SYM_DEPTH)-1:0] sym_waddr_i,
  input  logic                         sym_re_i,
  input  logic [$clog2(SYM_DEPTH)-1:0] sym_raddr_i,
  output logic [7:0]                   sym_rdata_o
);

  logic [7:0] cnt_mem [CNT_DEPTH];
  logic [7:0] sym_mem [SYM_DEPTH];

  // count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we_i) begin
      cnt_mem[cnt_waddr_i] <= wdata_i;
    end
    if (cnt_re_i) begin
      cnt_rdata_o <= cnt_mem[cnt_raddr_i];
    end
  end

  // symbol memory
  always_ff @(posedge clk_i) begin
    if (sym_we_i) begin
      sym_mem[sym_waddr_i] <= wdata_i;
    end
    if (sym_re_i) begin
      sym_rdata_o <= sym_mem[sym_raddr_i];
    end
  end

endmodule

>>> sim/tb_jpeg_huffman_block_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_jpeg_huffman_block_decoder_core
// Self-checking bench for the baseline JPEG entropy decoder core. Tables are
// loaded over the input channel. Scan streams are built from the loaded
// canonical codes, with errors, stalls and noise mixed in. Every coefficient
// beat is checked against a bit-level prediction of the decoder.
// ----------------------------------------------------------------------------
module tb_jpeg_huffman_block_decoder_core;
  import jhd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SymsPerPair = DcSymbolsDef + AcSymbolsDef;
  localparam int IdleLimit   = 20000;

  localparam int T0_DC_CNT [16] = '{0, 1, 5, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
  localparam int T0_AC_CNT [16] = '{0, 2, 1, 3, 3, 2, 4, 3, 5, 5, 4, 4, 0, 0, 1, 125};
  localparam int T1_DC_SYM [12] = '{11, 0, 12, 15, 1, 2, 3, 4, 5, 6, 7, 8};
  localparam int T1_AC_SYM [16] = '{'h00, 'hf0, 'h0b, 'h3f, 'h01, 'h1a, 'hf5, 'h20,
                                    'h0a, 'hff, 'h11, 'h05, 'h40, 'h12, 'h0c, 'h33};

  // block generator styles
  localparam int GenMixed  = 0;
  localparam int GenFull   = 1;
  localparam int GenFaulty = 2;
  localparam int GenSatUp  = 3;
  localparam int GenSatDn  = 4;

  typedef struct packed {
    logic [5:0]         idx;
    logic signed [15:0] val;
    logic               last;
    status_e            st;
  } coef_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready_o;
  logic [1:0]        command;
  logic              entropy_bit;
  logic              table_id;
  logic              table_is_ac;
  logic [7:0]        load_position;
  logic [7:0]        load_value;
  logic [1:0]        predictor_select;
  logic              out_valid_o;
  logic              out_ready;
  logic [5:0]        coef_index_o;
  logic signed [15:0] coef_value_o;
  logic              block_last_o;
  logic [2:0]        status_o;

  jpeg_huffman_block_decoder_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .command_i          (command),
    .entropy_bit_i      (entropy_bit),
    .table_id_i         (table_id),
    .table_is_ac_i      (table_is_ac),
    .load_position_i    (load_position),
    .load_value_i       (load_value),
    .predictor_select_i (predictor_select),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .coef_index_o       (coef_index_o),
    .coef_value_o       (coef_value_o),
    .block_last_o       (block_last_o),
    .status_o           (status_o)
  );

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // decoder shadow state
  logic [7:0] cnt_tab [64];
  logic [7:0] sym_tab [2*SymsPerPair];
  int         dc_pred [3];
  int         acc, fcode, findex, clen;
  phase_e     ph;
  int         mag, bleft, cpos, apred;
  coef_t      coef_q [$];

  // wanted table contents and canonical codes derived from the loaded tables
  int want_cnt [64];
  int want_sym [2*SymsPerPair];
  int enc_code [4][256];
  int enc_len  [4][256];

  int errors, beats, results, blocks, burst_left, idle_cycles;
  bit gaps_on;
  int rx_mode, hold_req, hold_left, rx_tick;
  int blk_tbl, blk_sel;

  function automatic void push_coef(int idx, int val, bit last, status_e st);
    coef_t c;
    c.idx  = idx[5:0];
    c.val  = val[15:0];
    c.last = last;
    c.st   = st;
    coef_q.push_back(c);
  endfunction

  function automatic void clear_code();
    acc = 0; fcode = 0; findex = 0; clen = 0;
  endfunction

  function automatic void abort_block(status_e st);
    push_coef(0, 0, 1'b1, st);
    ph = PH_ERROR;
    clear_code();
  endfunction

  // coefficient at the current zigzag position, then advance
  function automatic void place_coef(int v);
    int p;
    p = cpos & 63;
    push_coef(ZIGZAG[p], v, p == 63, ST_OK);
    cpos = p + 1;
    if (cpos >= NumCoefs) begin
      cpos = 0;
      ph = PH_DC_SYM;
    end else begin
      ph = PH_AC_SYM;
    end
  endfunction

  function automatic void dc_finish(int diff);
    int p, v;
    p = apred > 2 ? 2 : apred;
    v = dc_pred[p] + diff;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    dc_pred[p] = v;
    cpos = 0;
    place_coef(v);
  endfunction

  // one bit of canonical search: symbol, -1 pending, -2 no code
  function automatic int huff_step(int b, int tbl, int ac);
    int size, cnt, idx, a;
    size = ac ? AcSymbolsDef : DcSymbolsDef;
    acc = ((acc << 1) | b) & 'hffff;
    clen++;
    if (clen > MaxCodeLenDef) return -2;
    cnt = cnt_tab[(tbl*2 + ac)*MaxCodeLenDef + clen - 1];
    if (acc >= fcode && acc - fcode < cnt) begin
      idx = findex + acc - fcode;
      if (idx < size) begin
        a = tbl*SymsPerPair + (ac ? DcSymbolsDef : 0) + idx;
        clear_code();
        return int'(sym_tab[a]);
      end
    end
    findex += cnt;
    if (findex > 255) findex = 255;
    fcode = (fcode + cnt) << 1;
    if (fcode > 'h1ffff) fcode = 'h1ffff;
    if (clen >= MaxCodeLenDef) return -2;
    return -1;
  endfunction

  function automatic void decode_beat(cmd_e c, logic b, logic t, logic a,
                                      logic [7:0] p, logic [7:0] v, logic [1:0] s);
    int ti, ai, ac, sym, run, sz, k, mv;
    ti = int'(t);
    ai = int'(a);
    case (c)
      CMD_LOAD_COUNT: begin
        if (p < MaxCodeLenDef) cnt_tab[(ti*2 + ai)*MaxCodeLenDef + p] = v;
      end
      CMD_LOAD_SYMBOL: begin
        if (p < (ai ? AcSymbolsDef : DcSymbolsDef))
          sym_tab[ti*SymsPerPair + (ai ? DcSymbolsDef : 0) + p] = v;
      end
      CMD_START: begin
        dc_pred = '{0, 0, 0};
        clear_code();
        ph = PH_DC_SYM;
        mag = 0; bleft = 0; cpos = 0; apred = 0;
      end
      default: begin
        if (ph == PH_DC_SYM || ph == PH_AC_SYM) begin
          ac = (ph == PH_AC_SYM);
          if (!ac && clen == 0) apred = s > 2 ? 2 : int'(s);
          sym = huff_step(int'(b), ti, ac);
          if (sym == -1) return;
          if (sym == -2) begin
            abort_block(ST_NO_CODE);
            return;
          end
          if (!ac) begin
            if (sym > DcSizeMax) abort_block(ST_DC_SIZE);
            else if (sym == 0) dc_finish(0);
            else begin
              ph = PH_DC_MAG; clen = sym; bleft = sym; mag = 0;
            end
            return;
          end
          // end of block: zero fill up to position 63
          if (sym == SymEob) begin
            while (cpos < NumCoefs) begin
              push_coef(ZIGZAG[cpos], 0, cpos == 63, ST_OK);
              cpos++;
            end
            cpos = 0;
            ph = PH_DC_SYM;
            return;
          end
          run = (sym == SymZrl) ? ZrlRun : sym >> 4;
          sz  = sym & 15;
          if (cpos + run >= NumCoefs) abort_block(ST_RUN_OVER);
          else if (sym != SymZrl && sz > AcSizeMax) abort_block(ST_AC_SIZE);
          else begin
            for (k = 0; k < run; k++) begin
              push_coef(ZIGZAG[cpos & 63], 0, 1'b0, ST_OK);
              cpos++;
            end
            if (sym == SymZrl) return;
            if (sz == 0) place_coef(0);
            else begin
              ph = PH_AC_MAG; clen = sz; bleft = sz; mag = 0;
            end
          end
        end else if (ph == PH_DC_MAG || ph == PH_AC_MAG) begin
          mag = ((mag << 1) | int'(b)) & 'h7ff;
          if (bleft > 0) bleft--;
          if (bleft != 0) return;
          k = clen > DcSizeMax ? DcSizeMax : clen;
          if (k == 0) mv = 0;
          else if (((mag >> (k - 1)) & 1) == 0) mv = mag - ((1 << k) - 1);
          else mv = mag;
          clen = 0;
          mag = 0;
          if (ph == PH_DC_MAG) dc_finish(mv);
          else place_coef(mv);
        end
      end
    endcase
  endfunction

  // canonical code assignment from the tables as loaded
  function automatic void build_codes();
    int t, l, n, code, k, size;
    for (t = 0; t < 4; t++) begin
      size = (t & 1) ? AcSymbolsDef : DcSymbolsDef;
      code = 0;
      k = 0;
      for (l = 1; l <= MaxCodeLenDef; l++) begin
        for (n = 0; n < cnt_tab[t*MaxCodeLenDef + l - 1]; n++) begin
          if (k < size) begin
            enc_code[t][k] = code;
            enc_len[t][k]  = l;
          end
          k++;
          code++;
        end
        code = code << 1;
      end
    end
  endfunction

  function automatic int sym_index(int t, int ac, int sym);
    int k, size;
    size = ac ? AcSymbolsDef : DcSymbolsDef;
    for (k = 0; k < size; k++)
      if (sym_tab[t*SymsPerPair + (ac ? DcSymbolsDef : 0) + k] == sym) return k;
    return 0;
  endfunction

  function automatic void plan_tables();
    int k, r, s;
    for (k = 0; k < 16; k++) begin
      want_cnt[k]      = T0_DC_CNT[k];
      want_cnt[16 + k] = T0_AC_CNT[k];
      want_cnt[32 + k] = (k < 12) ? 1 : (k == 12) ? 2 : 0;
      want_cnt[48 + k] = 1;
    end
    for (k = 0; k < DcSymbolsDef; k++) begin
      want_sym[k] = k;
      want_sym[SymsPerPair + k] = T1_DC_SYM[k];
    end
    want_sym[DcSymbolsDef]     = SymEob;
    want_sym[DcSymbolsDef + 1] = SymZrl;
    k = 2;
    for (r = 0; r < 16; r++)
      for (s = 1; s <= AcSizeMax; s++) begin
        want_sym[DcSymbolsDef + k] = (r << 4) | s;
        k++;
      end
    for (k = 0; k < AcSymbolsDef; k++)
      want_sym[SymsPerPair + DcSymbolsDef + k] = (k < 16) ? T1_AC_SYM[k] : $urandom_range(0, 255);
  endfunction

  task automatic report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // one input beat; prediction runs at the accepting edge
  task automatic put_beat(cmd_e c, logic b, logic t, logic a,
                          logic [7:0] p, logic [7:0] v, logic [1:0] s);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid         <= 1'b1;
    command          <= c;
    entropy_bit      <= b;
    table_id         <= t;
    table_is_ac      <= a;
    load_position    <= p;
    load_value       <= v;
    predictor_select <= s;
    do @(posedge clk_i); while (!in_ready_o);
    decode_beat(c, b, t, a, p, v, s);
    beats++;
  endtask

  task automatic send_bit(int b);
    put_beat(CMD_BIT, b[0], blk_tbl[0], 1'($urandom), 8'($urandom), 8'($urandom),
             blk_sel[1:0]);
  endtask

  task automatic send_code(int t, int ac, int k);
    int i, pair;
    pair = t*2 + ac;
    for (i = enc_len[pair][k] - 1; i >= 0; i--) send_bit((enc_code[pair][k] >> i) & 1);
  endtask

  task automatic send_start();
    put_beat(CMD_START, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
             8'($urandom), 2'($urandom));
  endtask

  task automatic write_table(int t);
    int a, k;
    for (a = 0; a < 2; a++) begin
      for (k = 0; k < MaxCodeLenDef; k++)
        put_beat(CMD_LOAD_COUNT, 1'($urandom), t[0], a[0], 8'(k),
                 8'(want_cnt[(t*2 + a)*16 + k]), 2'($urandom));
      for (k = 0; k < (a ? AcSymbolsDef : DcSymbolsDef); k++)
        put_beat(CMD_LOAD_SYMBOL, 1'($urandom), t[0], a[0], 8'(k),
                 8'(want_sym[t*SymsPerPair + (a ? DcSymbolsDef : 0) + k]), 2'($urandom));
    end
  endtask

  // stop offering and let every expected coefficient come out
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (coef_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int pick_ac(int style);
    int r, run;
    if (style == GenSatUp || style == GenSatDn) return 0;
    if (style == GenFaulty) return $urandom_range(0, 15);
    r = $urandom_range(0, 99);
    if (style == GenMixed && r < 10) return sym_index(0, 1, SymEob);
    if (r < 16 && cpos + ZrlRun < NumCoefs) return sym_index(0, 1, SymZrl);
    if (r < 18) return $urandom_range(0, AcSymbolsDef - 1);
    run = (style == GenFull) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    if (run > 63 - cpos) run = 63 - cpos;
    return sym_index(0, 1, (run << 4) | $urandom_range(1, AcSizeMax));
  endfunction

  // one block, steered by the shadow state
  task automatic run_block(int style);
    bit dc_sent;
    dc_sent = 0;
    blk_tbl = (style == GenMixed || style == GenFull) ? 0 : 1;
    blk_sel = (style >= GenSatUp) ? 1 : $urandom_range(0, 3);
    forever begin
      if (ph == PH_ERROR || (dc_sent && ph == PH_DC_SYM)) break;
      case (ph)
        PH_DC_SYM: begin
          if (style >= GenSatUp) send_code(1, 0, 0);
          else if (style == GenFaulty) send_code(1, 0, $urandom_range(0, 11));
          else send_code(0, 0, sym_index(0, 0, $urandom_range(0, DcSizeMax)));
          dc_sent = 1;
        end
        PH_AC_SYM: send_code(blk_tbl, 1, pick_ac(style));
        default: send_bit(style == GenSatUp ? 1 : style == GenSatDn ? 0 : $urandom_range(0, 1));
      endcase
    end
    blocks++;
    if (ph == PH_ERROR) send_start();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_table_load();
    plan_tables();
    write_table(0);
    write_table(1);
    // loads outside the tables are dropped
    put_beat(CMD_LOAD_COUNT, 1'b0, 1'b0, 1'b0, 8'd16, 8'hAA, 2'd0);
    put_beat(CMD_LOAD_COUNT, 1'b1, 1'b1, 1'b1, 8'd255, 8'hFF, 2'd3);
    put_beat(CMD_LOAD_SYMBOL, 1'b0, 1'b0, 1'b0, 8'd12, 8'h55, 2'd0);
    put_beat(CMD_LOAD_SYMBOL, 1'b1, 1'b0, 1'b1, 8'd162, 8'h00, 2'd1);
    put_beat(CMD_LOAD_SYMBOL, 1'b0, 1'b1, 1'b1, 8'd255, 8'hFF, 2'd2);
    build_codes();
  endtask

  task automatic test_directed();
    int i;
    send_start();
    // largest positive DC size with predictor select 3, then end of block
    blk_tbl = 1;
    blk_sel = 3;
    send_code(1, 0, 0);
    for (i = 0; i < DcSizeMax; i++) send_bit(1);
    send_code(1, 1, 0);
    // sixteen ones match no DC code
    blk_tbl = 0;
    blk_sel = 0;
    for (i = 0; i < MaxCodeLenDef; i++) send_bit(1);
    // sticky error swallows this bit
    send_bit(0);
    send_start();
    drain();
  endtask

  task automatic test_blocks();
    int i;
    gaps_on = 1;
    rx_mode = 1;
    for (i = 0; i < 6; i++) run_block(GenMixed);
    run_block(GenFull);
    gaps_on = 0;
    rx_mode = 0;
    run_block(GenMixed);
  endtask

  task automatic test_back_pressure();
    hold_req = 400;
    run_block(GenFull);
    run_block(GenMixed);
    drain();
  endtask

  task automatic test_faulty_blocks();
    int i;
    gaps_on = 1;
    rx_mode = 2;
    for (i = 0; i < 14; i++) begin
      // code past the table, then no code at all
      if (i == 7) begin
        blk_tbl = 1;
        repeat (MaxCodeLenDef) send_bit(1);
        send_start();
      end
      run_block(GenFaulty);
    end
    drain();
  endtask

  task automatic test_saturation();
    int i;
    rx_mode = 1;
    send_start();
    for (i = 0; i < 17; i++) run_block(GenSatUp);
    send_start();
    for (i = 0; i < 17; i++) run_block(GenSatDn);
    drain();
  endtask

  // random tables, random commands, random bits
  task automatic test_noise();
    int i, r;
    for (i = 0; i < 64; i++) want_cnt[32 + (i & 31)] = (i & 7) == 0 ? 255 : $urandom_range(0, 255);
    for (i = 0; i < SymsPerPair; i++) want_sym[SymsPerPair + i] = $urandom_range(0, 255);
    write_table(1);
    send_start();
    rx_mode = 1;
    for (i = 0; i < 90; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_start();
      else if (r < 10)
        put_beat(cmd_e'($urandom_range(1, 2)), 1'($urandom), 1'b1, 1'($urandom),
                 8'($urandom), 8'($urandom), 2'($urandom));
      else
        put_beat(CMD_BIT, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                 8'($urandom), 2'($urandom));
    end
    drain();
  endtask

  // receiver: long hold-off on request, else always ready, random stalls or a stall pattern
  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    coef_t e;
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles", IdleLimit);
        $display("tb_jpeg_huffman_block_decoder_core failed");
        $finish;
      end
      if (out_valid_o && out_ready) begin
        results++;
        if (coef_q.size() == 0) begin
          report($sformatf("unexpected coef idx %0d val %0d", coef_index_o, coef_value_o));
        end else begin
          e = coef_q.pop_front();
          if (coef_index_o !== e.idx)
            report($sformatf("coef_index %0d, want %0d", coef_index_o, e.idx));
          if (coef_value_o !== e.val)
            report($sformatf("coef_value %0d, want %0d (idx %0d)", coef_value_o, e.val, e.idx));
          if (block_last_o !== e.last)
            report($sformatf("block_last %0b, want %0b (idx %0d)", block_last_o, e.last, e.idx));
          if (status_o !== e.st)
            report($sformatf("status %0d, want %0d", status_o, e.st));
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    command = CMD_BIT;
    entropy_bit = 1'b0;
    table_id = 1'b0;
    table_is_ac = 1'b0;
    load_position = '0;
    load_value = '0;
    predictor_select = '0;
    out_ready = 1'b0;
    errors = 0; beats = 0; results = 0; blocks = 0; burst_left = 0; idle_cycles = 0;
    gaps_on = 0; rx_mode = 0; hold_req = 0; hold_left = 0; rx_tick = 0;
    blk_tbl = 0; blk_sel = 0;
    cnt_tab = '{default: '0};
    sym_tab = '{default: '0};
    dc_pred = '{0, 0, 0};
    clear_code();
    ph = PH_DC_SYM;
    mag = 0; bleft = 0; cpos = 0; apred = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_load();
    test_directed();
    test_blocks();
    test_back_pressure();
    test_faulty_blocks();
    test_saturation();
    test_noise();

    repeat (50) @(posedge clk_i);
    if (coef_q.size() != 0) report($sformatf("%0d coefficients never came", coef_q.size()));
    $display("run covered %0d input beats, %0d blocks, %0d coefficient beats", beats, blocks,
             results);
    $display("table loads, error codes, DC saturation, back-pressure and noise were exercised");
    if (errors == 0) begin
      $display("tb_jpeg_huffman_block_decoder_core passed");
    end else begin
      $display("tb_jpeg_huffman_block_decoder_core failed");
    end
    $finish;
  end

endmodule

>>> jpeg_huffman_block_decoder_core.f
rtl/core/jhd_pkg.sv
rtl/core/jhd_tables.sv
rtl/core/jpeg_huffman_block_decoder_core.sv
sim/tb_jpeg_huffman_block_decoder_core.sv
